FILE: hw/rtl/crcg_pkg.sv
// Shared types and constants for the Catmull-Rom curve generator.
// Standalone package; imported by catmull_rom_curve_generator.
package crcg_pkg;

  // segment step count limits and reset value
  localparam logic [5:0] STEPS_MIN   = 6'd1;
  localparam logic [5:0] STEPS_MAX   = 6'd32;
  localparam logic [5:0] STEPS_RESET = 6'd20;

  // configuration register indexes
  localparam logic REG_IDX_STEPS = 1'b0;

  // signed weight width: |w| <= 2*32^3
  localparam int WGT_W  = 18;
  // unsigned width of j^2, j^3, n^2, n^3 and the mixed products
  localparam int SM_W   = 17;
  // divisor width: d = 2*n^3 <= 2^16
  localparam int D_W    = 17;
  // width used while forming the weights
  localparam int CALC_W = 22;

  // sequencer counts
  localparam logic [2:0] MAC_TERMS = 3'd4;
  localparam logic [1:0] AXIS_LAST = 2'd2;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_N2,
    ST_N3,
    ST_J2,
    ST_J3,
    ST_JN2,
    ST_J2N,
    ST_WGT,
    ST_MAC,
    ST_PREP,
    ST_DIV,
    ST_FIN,
    ST_OUT,
    ST_DONE
  } cr_state_t;

  // control point sources: window slots or the new waypoint
  typedef enum logic [1:0] {
    SRC_W0  = 2'd0,
    SRC_W1  = 2'd1,
    SRC_W2  = 2'd2,
    SRC_NEW = 2'd3
  } cr_src_t;

endpackage

FILE: hw/rtl/catmull_rom_curve_generator.sv
// Uniform Catmull-Rom curve generator: waypoint window, shared multiplier,
// bit-serial divider and sequencer. Depends on crcg_pkg.

// One waypoint is accepted at a time; in_tready is high only while the block
// is idle. A waypoint yields 0, n or 2n curve points (n = steps_per_segment,
// clamped to 1..32). For every point, four passes of the shared multiplier
// form the weights, then per axis a multiply-accumulate over the four terms
// and a restoring divider that retires one quotient bit a cycle form the
// coordinate; the point is held on the output register until it is taken.
// Each point is the exact weighted sum divided by 2*n^3, rounded half up
// and saturated.
module catmull_rom_curve_generator
  import crcg_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // input waypoint stream
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // way_x, way_y, way_z from bit 0 up, zero padded to bytes
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]     in_tdata,
  input  logic                                   in_tlast,   // path_end
  // output curve point stream
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // curve_x, curve_y, curve_z from bit 0 up, zero padded to bytes
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0]     out_tdata,
  output logic                                   out_tlast,  // run_last
  // configuration port
  input  logic                                   cfg_psel,
  input  logic                                   cfg_penable,
  input  logic                                   cfg_pwrite,
  input  logic [2:0]                             cfg_paddr,
  input  logic [31:0]                            cfg_pwdata,
  output logic [31:0]                            cfg_prdata,
  output logic                                   cfg_pready
);

  localparam int CW      = COORD_WIDTH;
  localparam int TDATA_W = ((3*COORD_WIDTH+7)/8)*8;
  localparam int ACC_W   = COORD_WIDTH + 20;
  localparam int Q_W     = COORD_WIDTH + 1;
  localparam int DCNT_W  = $clog2(Q_W);
  localparam int MUL_W   = COORD_WIDTH + WGT_W;
  localparam logic signed [Q_W:0] SAT_HI = $signed({3'b000, {(COORD_WIDTH-1){1'b1}}});
  localparam logic signed [Q_W:0] SAT_LO = $signed({3'b111, {(COORD_WIDTH-1){1'b0}}});

  cr_state_t state_r, state_nxt;

  logic [5:0]              steps_r;
  logic [5:0]              n_eff;
  logic [5:0]              n_r;
  logic [5:0]              j_r;
  logic [1:0]              seen_r;
  logic                    end_r;
  logic                    has_a_r;
  logic                    has_b_r;
  logic                    seg_r;
  logic                    has_a;
  logic                    has_b;
  cr_src_t                 a_sel [4];
  cr_src_t                 b_sel [4];
  cr_src_t                 a_sel_r [4];
  cr_src_t                 b_sel_r [4];
  cr_src_t                 cur_src;

  logic signed [CW-1:0]    win_r [3][3];
  logic signed [CW-1:0]    newp_r [3];
  logic signed [CW-1:0]    coord;

  logic [SM_W-1:0]         n2_r, n3_r, j2_r, j3_r, a_r, b_r;
  logic signed [CALC_W-1:0] ca, cb, cj3, cn3;
  logic signed [CALC_W-1:0] wc [4];
  logic signed [WGT_W-1:0] w_r [4];

  logic signed [CW-1:0]    mul_a;
  logic signed [WGT_W-1:0] mul_b;
  logic signed [MUL_W-1:0] mul_p;
  logic signed [MUL_W-1:0] prod_r;
  logic [2:0]              k_r;
  logic [1:0]              axis_r;
  logic signed [ACC_W-1:0] acc_r;

  logic [D_W-1:0]          d_w;
  logic [ACC_W-1:0]        div_m;
  logic [D_W-1:0]          rem_r;
  logic [Q_W-1:0]          quo_r;
  logic                    neg_r;
  logic [DCNT_W-1:0]       div_cnt_r;
  logic [D_W:0]            trial;
  logic [D_W:0]            trial_sub;
  logic                    trial_ge;

  logic signed [Q_W:0]     q_signed;
  logic [CW-1:0]           q_sat;
  logic [CW-1:0]           res_r [3];

  logic                    in_acc;
  logic                    out_acc;
  logic                    last_pt;
  logic                    more_pts;
  logic                    to_seg_b;

  // configuration register
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r <= STEPS_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr[2] == REG_IDX_STEPS) begin
      steps_r <= cfg_pwdata[5:0];
    end
  end
  assign cfg_prdata = (cfg_paddr[2] == REG_IDX_STEPS) ? 32'(steps_r) : 32'd0;

  // step count clamp and segment plan for the incoming waypoint
  always_comb begin
    if (steps_r < STEPS_MIN) begin
      n_eff = STEPS_MIN;
    end else if (steps_r > STEPS_MAX) begin
      n_eff = STEPS_MAX;
    end else begin
      n_eff = steps_r;
    end
    has_a = (seen_r >= 2'd2);
    has_b = in_tlast && (seen_r != 2'd0);
    a_sel = '{SRC_W0, SRC_W1, SRC_W2, SRC_NEW};
    b_sel = '{SRC_W1, SRC_W2, SRC_NEW, SRC_NEW};
    case (seen_r)
      2'd1: begin
        b_sel = '{SRC_W0, SRC_W0, SRC_NEW, SRC_NEW};
      end
      2'd2: begin
        a_sel = '{SRC_W0, SRC_W0, SRC_W1, SRC_NEW};
        b_sel = '{SRC_W0, SRC_W1, SRC_NEW, SRC_NEW};
      end
      default: ;
    endcase
  end

  // handshake and sequencing conditions
  assign in_acc   = in_tvalid && in_tready;
  assign out_acc  = out_tvalid && out_tready;
  assign more_pts = (j_r != n_r);
  assign to_seg_b = !seg_r && has_b_r;
  assign last_pt  = !more_pts && !to_seg_b;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_N2;
      ST_N2:   state_nxt = ST_N3;
      ST_N3:   state_nxt = (has_a_r || has_b_r) ? ST_J2 : ST_DONE;
      ST_J2:   state_nxt = ST_J3;
      ST_J3:   state_nxt = ST_JN2;
      ST_JN2:  state_nxt = ST_J2N;
      ST_J2N:  state_nxt = ST_WGT;
      ST_WGT:  state_nxt = ST_MAC;
      ST_MAC:  if (k_r == MAC_TERMS) state_nxt = ST_PREP;
      ST_PREP: state_nxt = ST_DIV;
      ST_DIV:  if (div_cnt_r == DCNT_W'(Q_W - 1)) state_nxt = ST_FIN;
      ST_FIN:  state_nxt = (axis_r == AXIS_LAST) ? ST_OUT : ST_MAC;
      ST_OUT: begin
        if (out_acc) begin
          state_nxt = last_pt ? ST_DONE : ST_J2;
        end
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // handshake outputs
  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      ST_IDLE: in_tready  = 1'b1;
      ST_OUT:  out_tvalid = 1'b1;
      default: ;
    endcase
  end

  assign out_tdata = TDATA_W'({res_r[2], res_r[1], res_r[0]});
  assign out_tlast = out_tvalid && last_pt;

  // control point select for the current term and axis
  assign cur_src = seg_r ? b_sel_r[k_r[1:0]] : a_sel_r[k_r[1:0]];
  assign coord   = (cur_src == SRC_NEW) ? newp_r[axis_r] : win_r[cur_src][axis_r];

  // shared multiplier operand select
  always_comb begin
    mul_a = coord;
    mul_b = w_r[k_r[1:0]];
    case (state_r)
      ST_N2:  begin mul_a = CW'(n_r);  mul_b = WGT_W'(n_r); end
      ST_N3:  begin mul_a = CW'(n2_r); mul_b = WGT_W'(n_r); end
      ST_J2:  begin mul_a = CW'(j_r);  mul_b = WGT_W'(j_r); end
      ST_J3:  begin mul_a = CW'(j2_r); mul_b = WGT_W'(j_r); end
      ST_JN2: begin mul_a = CW'(n2_r); mul_b = WGT_W'(j_r); end
      ST_J2N: begin mul_a = CW'(j2_r); mul_b = WGT_W'(n_r); end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // basis weights scaled by 2*n^3
  always_comb begin
    ca    = $signed(CALC_W'(a_r));
    cb    = $signed(CALC_W'(b_r));
    cj3   = $signed(CALC_W'(j3_r));
    cn3   = $signed(CALC_W'(n3_r));
    wc[0] = -ca + (cb <<< 1) - cj3;
    wc[1] = (cn3 <<< 1) - (cb <<< 2) - cb + (cj3 <<< 1) + cj3;
    wc[2] = ca + (cb <<< 2) - (cj3 <<< 1) - cj3;
    wc[3] = cj3 - cb;
  end

  // divider: d = 2*n^3, operand made nonnegative for floor division
  assign d_w   = {n3_r[D_W-2:0], 1'b0};
  assign div_m = acc_r[ACC_W-1] ? (~acc_r + ACC_W'(d_w)) : acc_r;
  assign trial     = {rem_r, quo_r[Q_W-1]};
  assign trial_ge  = (trial >= {1'b0, d_w});
  assign trial_sub = trial - {1'b0, d_w};

  // sign restore and saturation
  always_comb begin
    q_signed = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
    if (q_signed > SAT_HI) begin
      q_sat = SAT_HI[CW-1:0];
    end else if (q_signed < SAT_LO) begin
      q_sat = SAT_LO[CW-1:0];
    end else begin
      q_sat = q_signed[CW-1:0];
    end
  end

  // window and point count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 2'd0;
      for (int s = 0; s < 3; s++) begin
        for (int a = 0; a < 3; a++) begin
          win_r[s][a] <= '0;
        end
      end
    end else if (state_r == ST_DONE) begin
      if (end_r) begin
        seen_r <= 2'd0;
        for (int s = 0; s < 3; s++) begin
          for (int a = 0; a < 3; a++) begin
            win_r[s][a] <= '0;
          end
        end
      end else if (seen_r == 2'd3) begin
        for (int a = 0; a < 3; a++) begin
          win_r[0][a] <= win_r[1][a];
          win_r[1][a] <= win_r[2][a];
          win_r[2][a] <= newp_r[a];
        end
      end else begin
        seen_r <= seen_r + 2'd1;
        for (int a = 0; a < 3; a++) begin
          win_r[seen_r][a] <= newp_r[a];
        end
      end
    end
  end

  // sequencer control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_r     <= 1'b0;
      has_a_r   <= 1'b0;
      has_b_r   <= 1'b0;
      seg_r     <= 1'b0;
      j_r       <= STEPS_MIN;
      n_r       <= STEPS_MIN;
      k_r       <= 3'd0;
      axis_r    <= 2'd0;
      div_cnt_r <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            end_r   <= in_tlast;
            has_a_r <= has_a;
            has_b_r <= has_b;
            seg_r   <= !has_a;
            j_r     <= STEPS_MIN;
            n_r     <= n_eff;
          end
        end
        ST_WGT: begin
          k_r    <= 3'd0;
          axis_r <= 2'd0;
        end
        ST_MAC:  k_r <= k_r + 3'd1;
        ST_PREP: div_cnt_r <= '0;
        ST_DIV:  div_cnt_r <= div_cnt_r + DCNT_W'(1);
        ST_FIN: begin
          k_r    <= 3'd0;
          axis_r <= axis_r + 2'd1;
        end
        ST_OUT: begin
          if (out_acc) begin
            if (more_pts) begin
              j_r <= j_r + 6'd1;
            end else if (to_seg_b) begin
              seg_r <= 1'b1;
              j_r   <= STEPS_MIN;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          newp_r[0] <= in_tdata[CW-1:0];
          newp_r[1] <= in_tdata[2*CW-1:CW];
          newp_r[2] <= in_tdata[3*CW-1:2*CW];
          a_sel_r   <= a_sel;
          b_sel_r   <= b_sel;
        end
      end
      ST_N2:  n2_r <= mul_p[SM_W-1:0];
      ST_N3:  n3_r <= mul_p[SM_W-1:0];
      ST_J2:  j2_r <= mul_p[SM_W-1:0];
      ST_J3:  j3_r <= mul_p[SM_W-1:0];
      ST_JN2: a_r  <= mul_p[SM_W-1:0];
      ST_J2N: b_r  <= mul_p[SM_W-1:0];
      ST_WGT: begin
        for (int i = 0; i < 4; i++) begin
          w_r[i] <= wc[i][WGT_W-1:0];
        end
        // rounding bias: half the divisor
        acc_r <= $signed(ACC_W'(n3_r));
      end
      ST_MAC: begin
        // product of term k, accumulate of term k-1
        if (k_r != MAC_TERMS) begin
          prod_r <= mul_p;
        end
        if (k_r != 3'd0) begin
          acc_r <= acc_r + ACC_W'(prod_r);
        end
      end
      ST_PREP: begin
        neg_r <= acc_r[ACC_W-1];
        rem_r <= div_m[Q_W+D_W-1:Q_W];
        quo_r <= div_m[Q_W-1:0];
      end
      ST_DIV: begin
        rem_r <= trial_ge ? trial_sub[D_W-1:0] : trial[D_W-1:0];
        quo_r <= {quo_r[Q_W-2:0], trial_ge};
      end
      ST_FIN: begin
        res_r[axis_r] <= q_sat;
        acc_r         <= $signed(ACC_W'(n3_r));
      end
      default: ;
    endcase
  end

  // checks
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("input accepted while a curve point is pending");

  a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tlast |-> (j_r == n_r))
    else $error("run_last before the final step of a segment");

  a_path_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) && end_r |=> (seen_r == 2'd0))
    else $error("window not cleared after path end");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (div_cnt_r <= DCNT_W'(Q_W - 1)))
    else $error("divider ran past its last quotient bit");

endmodule

FILE: bench/testbench.sv
// Self-checking bench for catmull_rom_curve_generator: waypoint paths go in over the
// input stream, every curve point is predicted and compared in order.
// Depends on crcg_pkg and the generator RTL only.
module testbench;
  import crcg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0]  STEPS_ADDR   = {REG_IDX_STEPS, 2'b00};
  localparam int          STALL_LIMIT  = 5000;   // cycles without any transaction
  localparam int          SETTLE_CYCLES = 300;   // > one point plus wrap-up
  localparam logic [31:0] C_MAX = 32'h7fff_ffff;
  localparam logic [31:0] C_MIN = 32'h8000_0000;
  localparam longint      SAT_HI = 64'sd2147483647;
  localparam longint      SAT_LO = -64'sd2147483648;

  // x in the low bits, matching the tdata layout
  typedef struct packed {
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } waypoint_t;

  typedef struct packed {
    logic               last;
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } curve_pt_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;       // way_x, way_y, way_z from bit 0 up
  logic        in_tlast = 1'b0;     // path_end
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;           // curve_x, curve_y, curve_z from bit 0 up
  logic        out_tlast;           // run_last
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // predictor state
  waypoint_t   path_window [3];
  int          window_fill = 0;
  logic [5:0]  steps_reg = STEPS_RESET;
  curve_pt_t   pending_points [$];

  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  int          send_idle_pct = 37;
  int          recv_idle_pct = 54;

  catmull_rom_curve_generator u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Curve prediction
  // ---------------------------------------------------------------------------

  // one axis: exact weighted sum over 2n^3, rounded half up, saturated
  function automatic logic [31:0] blend_axis(longint p0, longint p1, longint p2,
                                             longint p3, longint j, longint n);
    longint n2, n3, j2, j3, acc, den, quo;
    n2 = n * n;
    n3 = n2 * n;
    j2 = j * j;
    j3 = j2 * j;
    den = 2 * n3;
    acc = p0 * (-j * n2 + 2 * j2 * n - j3)
        + p1 * (2 * n3 - 5 * j2 * n + 3 * j3)
        + p2 * (j * n2 + 4 * j2 * n - 3 * j3)
        + p3 * (j3 - j2 * n)
        + n3;                                   // half the divisor
    quo = acc / den;
    if (acc % den < 0) quo = quo - 1;           // floor division
    if (quo > SAT_HI) quo = SAT_HI;
    if (quo < SAT_LO) quo = SAT_LO;
    return quo[31:0];
  endfunction

  // queue the n points of one segment; the closing one flags the run end if closes_run
  task automatic push_segment(waypoint_t a, waypoint_t b, waypoint_t c, waypoint_t d,
                              int n, logic closes_run);
    curve_pt_t pt;
    int        k;
    for (int j = 1; j <= n; j++) begin
      for (k = 0; k < 3; k++)
        pt[32*k +: 32] = blend_axis(longint'($signed(a[32*k +: 32])),
                                    longint'($signed(b[32*k +: 32])),
                                    longint'($signed(c[32*k +: 32])),
                                    longint'($signed(d[32*k +: 32])),
                                    longint'(j), longint'(n));
      pt.last = closes_run && (j == n);
      pending_points.insert(pending_points.size(), pt);
    end
  endtask

  // advance the window for one accepted waypoint and queue its points
  task automatic track_waypoint(waypoint_t wp, logic path_end);
    int   n;
    logic end_seg;
    n = int'(steps_reg);
    if (n < STEPS_MIN) n = int'(STEPS_MIN);
    if (n > STEPS_MAX) n = int'(STEPS_MAX);
    end_seg = path_end && (window_fill >= 1);

    if (window_fill == 2)
      push_segment(path_window[0], path_window[0], path_window[1], wp, n, !end_seg);
    else if (window_fill == 3)
      push_segment(path_window[0], path_window[1], path_window[2], wp, n, !end_seg);

    if (end_seg) begin
      case (window_fill)
        1: push_segment(path_window[0], path_window[0], wp, wp, n, 1'b1);
        2: push_segment(path_window[0], path_window[1], wp, wp, n, 1'b1);
        default: push_segment(path_window[1], path_window[2], wp, wp, n, 1'b1);
      endcase
    end

    if (path_end) begin
      path_window[0] = '0;
      path_window[1] = '0;
      path_window[2] = '0;
      window_fill = 0;
    end else if (window_fill == 3) begin
      path_window[0] = path_window[1];
      path_window[1] = path_window[2];
      path_window[2] = wp;
    end else begin
      path_window[window_fill] = wp;
      window_fill++;
    end
  endtask

  task automatic note_mismatch(string what, logic [96:0] want, logic [96:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("[%0t] MISMATCH %s: expected %h, got %h (last/z/y/x)",
               $realtime, what, want, got);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random backpressure and in-order checking
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_points
    curve_pt_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tlast, out_tdata};
      if (pending_points.size() == 0) begin
        note_mismatch("curve point with none expected", '0, got);
      end else begin
        want = pending_points.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
            got.last !== want.last)
          note_mismatch("curve point", want, got);
      end
    end
  end

  // watchdog: no transaction of any kind for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // one waypoint transaction; tvalid is left high for a back-to-back follower
  task automatic send_waypoint(waypoint_t wp, logic path_end);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= wp;
    in_tlast  <= path_end;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    track_waypoint(wp, path_end);
  endtask

  // drop tvalid, wait for every expected point, then let the block wind down
  task automatic quiesce();
    in_tvalid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic read_steps();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= STEPS_ADDR;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== {26'd0, steps_reg})
      note_mismatch("steps_per_segment readback", {65'd0, 26'd0, steps_reg},
                    {65'd0, cfg_prdata});
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // write the step count, then read it straight back (psel stays high)
  task automatic program_steps(logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= STEPS_ADDR;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    steps_reg = value[5:0];
    read_steps();
  endtask

  function automatic waypoint_t waypoint(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    waypoint_t wp;
    wp.x = x;
    wp.y = y;
    wp.z = z;
    return wp;
  endfunction

  // mostly full-range values, with rails and small near-zero values mixed in
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(9))
      0:       return C_MAX;
      1:       return C_MIN;
      2, 3:    return $urandom_range(32'h000f_ffff) - 32'h0008_0000;
      default: return $urandom();
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset step count (20) and overshoot past both rails
  task automatic test_default_steps();
    read_steps();
    send_waypoint(waypoint(C_MAX, C_MIN, 32'h0), 1'b0);
    send_waypoint(waypoint(C_MIN, C_MAX, 32'hffff_ffff), 1'b0);
    send_waypoint(waypoint(C_MAX, C_MAX, C_MIN), 1'b1);
  endtask

  // single-waypoint path, two-waypoint path, and a path that fills the window
  task automatic test_short_paths();
    quiesce();
    program_steps(32'd1);
    send_waypoint(waypoint(32'h1234_5678, 32'h8765_4321, 32'h0001_0000), 1'b1);
    send_waypoint(waypoint(32'h0001_0000, 32'hfffe_0000, 32'h0), 1'b0);
    send_waypoint(waypoint(32'h0003_8000, 32'h0, 32'hffff_8000), 1'b1);
    send_waypoint(waypoint(C_MIN, C_MIN, C_MAX), 1'b0);
    send_waypoint(waypoint(C_MAX, C_MAX, C_MIN), 1'b0);
    send_waypoint(waypoint(C_MIN, C_MAX, C_MIN), 1'b0);
    send_waypoint(waypoint(C_MAX, C_MIN, C_MAX), 1'b1);
  endtask

  // largest step count: the closing waypoint yields two full segments
  task automatic test_long_segments();
    quiesce();
    program_steps(32'd32);
    send_waypoint(waypoint(32'haaaa_aaaa, 32'h5555_5555, C_MAX), 1'b0);
    send_waypoint(waypoint(32'h5555_5555, 32'haaaa_aaaa, C_MIN), 1'b0);
    send_waypoint(waypoint(32'hffff_ffff, 32'h0000_0001, 32'h7fff_0000), 1'b1);
  endtask

  // zero acts as one, above 32 acts as 32, upper write bits are dropped
  task automatic test_step_clamping();
    quiesce();
    program_steps(32'd0);
    send_waypoint(waypoint(32'h0010_0000, 32'hfff0_0000, 32'h0), 1'b0);
    send_waypoint(waypoint(32'hfff0_0001, 32'h000f_ffff, 32'h0000_0001), 1'b1);
    quiesce();
    program_steps(32'd63);
    send_waypoint(waypoint(C_MIN, 32'h0, C_MAX), 1'b0);
    send_waypoint(waypoint(C_MAX, 32'h0, C_MIN), 1'b1);
    quiesce();
    program_steps(32'hffff_ffc3);
    send_waypoint(waypoint(32'h0002_0000, 32'h0004_0000, 32'h0006_0000), 1'b0);
    send_waypoint(waypoint(32'hfffe_0000, 32'h0001_8000, 32'h0), 1'b0);
    send_waypoint(waypoint(32'h0000_8000, 32'hffff_0000, 32'h0003_0000), 1'b1);
  endtask

  // random paths of random length under one step count and one idling mix
  task automatic test_random_paths(int send_pct, int recv_pct, logic [5:0] steps,
                                   int waypoints);
    int sent;
    int path_len;
    sent = 0;
    quiesce();
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    program_steps({26'd0, steps});
    while (sent < waypoints) begin
      path_len = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
      for (int i = 0; i < path_len; i++)
        send_waypoint(waypoint(pick_coord(), pick_coord(), pick_coord()),
                      i == path_len - 1);
      sent += path_len;
    end
  endtask

  initial begin
    path_window[0] = '0;
    path_window[1] = '0;
    path_window[2] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_steps();
    test_short_paths();
    test_long_segments();
    test_step_clamping();

    test_random_paths(37, 54, 6'($urandom_range(1, 6)), 21);
    test_random_paths(37, 54, 6'($urandom_range(9, 16)), 21);
    test_random_paths(54, 37, 6'($urandom_range(1, 6)), 21);
    test_random_paths(54, 37, 6'($urandom_range(2, 8)), 21);
    test_random_paths(0, 0, 6'($urandom_range(1, 6)), 21);
    test_random_paths(0, 0, 6'($urandom_range(1, 4)), 21);

    quiesce();
    if (mismatch_count == 0 && pending_points.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
